// ===== rtl/assert_macros.svh =====
// Assertion helpers: all checks run on the rising edge of clk and stay quiet in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the cycle after.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ccl_pkg.sv =====
package ccl_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int FIFO_DEPTH      = 2;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [7:0]  ACK_BYTE = 8'hFF;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_MISMATCH   = 3'd1;
    localparam logic [2:0] ST_NO_PENDING = 3'd2;
    localparam logic [2:0] ST_BAD_ACK    = 3'd3;
    localparam logic [2:0] ST_QUEUE_FULL = 3'd4;

    localparam logic KIND_TX      = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef enum logic [2:0] {
        OP_SEND_DATA,
        OP_SEND_LAST,
        OP_REPLY_BYTE,
        OP_REPLY_LAST,
        OP_ACK
    } ccl_op_t;

    typedef struct packed {
        ccl_op_t    op;
        logic       start;
        logic       too_short;
        logic [7:0] data;
    } ccl_item_t;

    // CRC-16, polynomial 0x1021, MSB first, one byte per call
    function automatic logic [15:0] fold_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== rtl/ccl_front.sv =====
module ccl_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                direction,
    input  logic [7:0]          data_byte,
    input  logic                frame_last,
    input  logic                reply_is_ack,
    input  logic                q_ready,
    output logic                q_push,
    output ccl_pkg::ccl_item_t  q_item
);

    logic       frame_open_reg, frame_open_next;
    logic       frame_dir_reg, frame_dir_next;
    logic [1:0] rlen_reg, rlen_next;
    logic       open_same;
    logic [1:0] rlen_inc;

    assign in_ready = q_ready;
    assign q_push   = in_valid && q_ready;

    always_comb
    begin
        // a direction change drops the open frame
        open_same       = frame_open_reg && (frame_dir_reg == direction);
        rlen_inc        = open_same ? ((rlen_reg == 2'd3) ? 2'd3 : rlen_reg + 2'd1) : 2'd1;
        q_item.data      = data_byte;
        q_item.start     = !open_same;
        q_item.too_short = 1'b0;
        q_item.op        = ccl_pkg::OP_SEND_DATA;
        frame_open_next = 1'b0;
        frame_dir_next  = direction;
        rlen_next       = 2'd0;
        if (!direction)
        begin
            q_item.op       = frame_last ? ccl_pkg::OP_SEND_LAST : ccl_pkg::OP_SEND_DATA;
            frame_open_next = !frame_last;
        end
        else if (reply_is_ack)
        begin
            q_item.op = ccl_pkg::OP_ACK;
        end
        else
        begin
            q_item.op        = frame_last ? ccl_pkg::OP_REPLY_LAST : ccl_pkg::OP_REPLY_BYTE;
            q_item.too_short = (rlen_inc != 2'd3);
            frame_open_next  = !frame_last;
            rlen_next        = rlen_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
            frame_dir_reg  <= 1'b0;
            rlen_reg       <= 2'd0;
        end
        else if (q_push)
        begin
            frame_open_reg <= frame_open_next;
            frame_dir_reg  <= frame_dir_next;
            rlen_reg       <= rlen_next;
        end
    end

endmodule

// ===== rtl/ccl_fifo.sv =====
module ccl_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  ccl_pkg::ccl_item_t  wr_item,
    output logic                wr_ready,
    input  logic                rd_en,
    output ccl_pkg::ccl_item_t  rd_item,
    output logic                rd_valid
);

    localparam int PTR_W = (ccl_pkg::FIFO_DEPTH > 1) ? $clog2(ccl_pkg::FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(ccl_pkg::FIFO_DEPTH + 1);

    ccl_pkg::ccl_item_t slot_reg [ccl_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_wr, do_rd;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(ccl_pkg::FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign wr_ready = (cnt_reg != CNT_W'(ccl_pkg::FIFO_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_item  = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_en && wr_ready;
    assign do_rd    = rd_en && rd_valid;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/ccl_back.sv =====
module ccl_back #(
    parameter int QUEUE_DEPTH = ccl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  ccl_pkg::ccl_item_t  item,
    output logic                item_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                out_kind,
    output logic [7:0]          tx_byte,
    output logic                run_last,
    output logic [2:0]          status
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [15:0]      pend_mem [QUEUE_DEPTH];
    logic [15:0]      head_val_reg;
    logic [IDX_W-1:0] head_reg, head_next, tail_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [15:0] crc_reg, crc_next;
    logic        seed_missing_reg, seed_missing_next;
    logic [1:0]  extra_reg, extra_next;
    logic [15:0] hold_crc_reg, hold_crc_next;
    logic [2:0]  hold_st_reg, hold_st_next;

    logic        out_valid_reg, out_valid_next;
    logic        out_kind_reg, out_kind_next;
    logic [7:0]  tx_byte_reg, tx_byte_next;
    logic        run_last_reg, run_last_next;
    logic [2:0]  status_reg, status_next;

    logic        slot_free, pend_empty, pend_full, is_send, push_q, pop_q, seed_miss_eff;
    logic [15:0] crc_base, crc_fold;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
        return (p == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : p + IDX_W'(1);
    endfunction

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign tx_byte   = tx_byte_reg;
    assign run_last  = run_last_reg;
    assign status    = status_reg;

    assign slot_free  = !out_valid_reg || out_ready;
    assign item_pop   = item_valid && (extra_reg == 2'd0) && slot_free;
    assign pend_empty = (cnt_reg == '0);
    assign pend_full  = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign is_send    = (item.op == ccl_pkg::OP_SEND_DATA) || (item.op == ccl_pkg::OP_SEND_LAST);
    assign crc_base   = !item.start ? crc_reg
                      : (is_send || pend_empty) ? 16'h0000 : head_val_reg;
    assign crc_fold   = ccl_pkg::fold_byte(crc_base, item.data);
    assign seed_miss_eff = item.start ? pend_empty : seed_missing_reg;
    assign head_next  = pop_q ? wrap_inc(head_reg) : head_reg;

    always_comb
    begin
        crc_next          = crc_reg;
        seed_missing_next = seed_missing_reg;
        extra_next        = extra_reg;
        hold_crc_next     = hold_crc_reg;
        hold_st_next      = hold_st_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        out_kind_next     = out_kind_reg;
        tx_byte_next      = tx_byte_reg;
        run_last_next     = run_last_reg;
        status_next       = status_reg;
        push_q            = 1'b0;
        pop_q             = 1'b0;

        if (extra_reg != 2'd0 && slot_free)
        begin
            // drain the trailing CRC bytes, high byte first
            out_valid_next = 1'b1;
            out_kind_next  = ccl_pkg::KIND_TX;
            tx_byte_next   = (extra_reg == 2'd2) ? hold_crc_reg[15:8] : hold_crc_reg[7:0];
            run_last_next  = (extra_reg == 2'd1);
            status_next    = hold_st_reg;
            extra_next     = extra_reg - 2'd1;
        end
        else if (item_pop)
        begin
            unique case (item.op) inside
                ccl_pkg::OP_SEND_DATA:
                begin
                    crc_next       = crc_fold;
                    out_valid_next = 1'b1;
                    out_kind_next  = ccl_pkg::KIND_TX;
                    tx_byte_next   = item.data;
                    run_last_next  = 1'b1;
                    status_next    = ccl_pkg::ST_OK;
                end
                ccl_pkg::OP_SEND_LAST:
                begin
                    crc_next       = crc_fold;
                    push_q         = !pend_full;
                    hold_crc_next  = crc_fold;
                    hold_st_next   = pend_full ? ccl_pkg::ST_QUEUE_FULL : ccl_pkg::ST_OK;
                    extra_next     = 2'd2;
                    out_valid_next = 1'b1;
                    out_kind_next  = ccl_pkg::KIND_TX;
                    tx_byte_next   = item.data;
                    run_last_next  = 1'b0;
                    status_next    = ccl_pkg::ST_OK;
                end
                ccl_pkg::OP_REPLY_BYTE, ccl_pkg::OP_REPLY_LAST:
                begin
                    crc_next          = crc_fold;
                    seed_missing_next = seed_miss_eff;
                    pop_q             = item.start && !pend_empty;
                    if (item.op == ccl_pkg::OP_REPLY_LAST)
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = ccl_pkg::KIND_VERDICT;
                        tx_byte_next   = 8'h00;
                        run_last_next  = 1'b1;
                        if (seed_miss_eff)
                            status_next = ccl_pkg::ST_NO_PENDING;
                        else if (item.too_short || crc_fold != 16'h0000)
                            status_next = ccl_pkg::ST_MISMATCH;
                        else
                            status_next = ccl_pkg::ST_OK;
                    end
                end
                ccl_pkg::OP_ACK:
                begin
                    pop_q          = !pend_empty;
                    out_valid_next = 1'b1;
                    out_kind_next  = ccl_pkg::KIND_VERDICT;
                    tx_byte_next   = 8'h00;
                    run_last_next  = 1'b1;
                    if (pend_empty)
                        status_next = ccl_pkg::ST_NO_PENDING;
                    else if (item.data == ccl_pkg::ACK_BYTE)
                        status_next = ccl_pkg::ST_OK;
                    else
                        status_next = ccl_pkg::ST_BAD_ACK;
                end
                default:
                begin
                    out_valid_next = out_valid_reg && !out_ready;
                end
            endcase
        end
    end

    // pending CRC memory; the head slot is prefetched, with bypass of a same-cycle write
    always_ff @(posedge clk)
    begin
        if (push_q)
        begin
            pend_mem[tail_reg] <= crc_fold;
        end
        if (push_q && tail_reg == head_next)
        begin
            head_val_reg <= crc_fold;
        end
        else
        begin
            head_val_reg <= pend_mem[head_next];
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg       <= crc_next;
        hold_crc_reg  <= hold_crc_next;
        hold_st_reg   <= hold_st_next;
        out_kind_reg  <= out_kind_next;
        tx_byte_reg   <= tx_byte_next;
        run_last_reg  <= run_last_next;
        status_reg    <= status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg         <= '0;
            tail_reg         <= '0;
            cnt_reg          <= '0;
            seed_missing_reg <= 1'b0;
            extra_reg        <= 2'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            head_reg         <= head_next;
            seed_missing_reg <= seed_missing_next;
            extra_reg        <= extra_next;
            out_valid_reg    <= out_valid_next;
            if (push_q)
            begin
                tail_reg <= wrap_inc(tail_reg);
                cnt_reg  <= cnt_reg + CNT_W'(1);
            end
            else if (pop_q)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/chained_crc16_link_checker.sv =====
// Chained CRC-16 link checker (CRC-16/XMODEM: poly 0x1021, init 0, MSB first).
// Send beats (direction 0) pass through one result each; the final send beat
// also emits the frame CRC high byte then low byte and queues the CRC as
// pending (status 4 on both CRC bytes when the queue is full). A reply
// (direction 1) folds all its bytes from the oldest pending CRC, which it
// pops, and gives one verdict on its final beat: 0 ok, 1 mismatch or shorter
// than three bytes, 2 nothing pending. An acknowledge beat is a one-byte
// reply that must be 0xFF (else status 3) and pops the oldest CRC.
// Throughput: one input beat per cycle, one result per cycle on the output,
// while out_ready holds and no CRC bytes drain. A final send beat holds the
// output port for its data byte and both CRC bytes, so the front queue
// absorbs at most two more beats while it drains. An accepted input beat is
// registered in the front queue, and any result it gives then in the output
// register. The pending store is a memory with one write and one registered
// read of the head slot, refetched every cycle with bypass of a same-cycle
// write, so a new CRC is at the head from the edge that queues it when the
// queue was empty. No clearing pass runs after reset.
`include "assert_macros.svh"

module chained_crc16_link_checker #(
    parameter int QUEUE_DEPTH = ccl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       direction,
    input  logic [7:0] data_byte,
    input  logic       frame_last,
    input  logic       reply_is_ack,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       out_kind,
    output logic [7:0] tx_byte,
    output logic       run_last,
    output logic [2:0] status
);

    ccl_pkg::ccl_item_t push_item, pop_item;
    logic               q_push, q_ready, q_valid, q_pop;

    // Front: track frame boundaries and direction, classify each beat.
    ccl_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .direction    (direction),
        .data_byte    (data_byte),
        .frame_last   (frame_last),
        .reply_is_ack (reply_is_ack),
        .q_ready      (q_ready),
        .q_push       (q_push),
        .q_item       (push_item)
    );

    // Short queue: lets the front keep accepting while CRC bytes drain.
    ccl_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_item  (push_item),
        .wr_ready (q_ready),
        .rd_en    (q_pop),
        .rd_item  (pop_item),
        .rd_valid (q_valid)
    );

    // Back: fold CRCs, manage the pending queue, sequence the results.
    ccl_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_valid),
        .item       (pop_item),
        .item_pop   (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_kind   (out_kind),
        .tx_byte    (tx_byte),
        .run_last   (run_last),
        .status     (status)
    );

    // A result that does not close its run is always followed by a CRC byte.
    `ASSERT_NEXT(a_run_continues, out_valid && !run_last, out_valid, "run cut short")
    // Verdicts carry no byte and always close their run.
    `ASSERT_SAME(a_verdict_shape, out_valid && out_kind,
                 run_last && tx_byte == 8'h00, "bad verdict")
    // Transmit results only ever report ok or queue full.
    `ASSERT_SAME(a_tx_status, out_valid && !out_kind,
                 status == ccl_pkg::ST_OK || status == ccl_pkg::ST_QUEUE_FULL, "bad tx status")

endmodule

// ===== test/crc_link_sb_pkg.sv =====
`timescale 1ns / 100ps

package crc_link_sb_pkg;

    typedef struct {
        logic       kind;
        logic [7:0] tx;
        logic       last;
        logic [2:0] code;
    } link_result_t;

    class crc_link_scoreboard;

        int unsigned failures;

        // Frame state mirrored from the beats seen at the input
        local logic [15:0] crc_acc;
        local logic [15:0] saved_crcs [ccl_pkg::QUEUE_DEPTH_DEF];
        local int unsigned saved_count;
        local int unsigned rd_ptr;
        local int unsigned wr_ptr;
        local bit          in_frame;
        local bit          frame_dir;
        local int unsigned reply_len;
        local bit          unseeded;
        local link_result_t outcomes [$];

        function new();
            failures    = 0;
            saved_count = 0;
            rd_ptr      = 0;
            wr_ptr      = 0;
            frame_dir   = 1'b0;
            close_frame();
        endfunction

        // Shift one byte through the CRC register, MSB first
        static function logic [15:0] crc_fold(logic [15:0] crc, logic [7:0] b);
            logic [15:0] acc;
            logic        fb;
            acc = crc;
            for (int i = 7; i >= 0; i--)
            begin
                fb  = acc[15] ^ b[i];
                acc = {acc[14:0], 1'b0} ^ (fb ? ccl_pkg::CRC_POLY : 16'h0000);
            end
            return acc;
        endfunction

        function logic [15:0] crc_now();
            return crc_acc;
        endfunction

        function int unsigned pending_depth();
            return saved_count;
        endfunction

        function int unsigned waiting();
            return outcomes.size();
        endfunction

        local function void close_frame();
            in_frame  = 1'b0;
            crc_acc   = 16'h0000;
            reply_len = 0;
            unseeded  = 1'b0;
        endfunction

        local function logic [15:0] pop_saved();
            logic [15:0] v;
            v           = saved_crcs[rd_ptr];
            rd_ptr      = (rd_ptr + 1) % ccl_pkg::QUEUE_DEPTH_DEF;
            saved_count = saved_count - 1;
            return v;
        endfunction

        local function void add_outcome(logic kind, logic [7:0] tx, logic last,
                                        logic [2:0] code);
            link_result_t r;
            r.kind = kind;
            r.tx   = tx;
            r.last = last;
            r.code = code;
            outcomes.push_back(r);
        endfunction

        // Work out what one accepted input beat must produce
        function void note_beat(logic dir, logic [7:0] b, logic last, logic ack);
            logic [2:0] verdict;
            if (in_frame && frame_dir != dir)
                close_frame();

            if (dir == 1'b0)
            begin
                if (!in_frame)
                begin
                    crc_acc   = 16'h0000;
                    in_frame  = 1'b1;
                    frame_dir = 1'b0;
                end
                crc_acc = crc_fold(crc_acc, b);
                if (!last)
                begin
                    add_outcome(ccl_pkg::KIND_TX, b, 1'b1, ccl_pkg::ST_OK);
                    return;
                end
                verdict = ccl_pkg::ST_OK;
                if (saved_count < ccl_pkg::QUEUE_DEPTH_DEF)
                begin
                    saved_crcs[wr_ptr] = crc_acc;
                    wr_ptr             = (wr_ptr + 1) % ccl_pkg::QUEUE_DEPTH_DEF;
                    saved_count        = saved_count + 1;
                end
                else
                    verdict = ccl_pkg::ST_QUEUE_FULL;
                add_outcome(ccl_pkg::KIND_TX, b, 1'b0, ccl_pkg::ST_OK);
                add_outcome(ccl_pkg::KIND_TX, crc_acc[15:8], 1'b0, verdict);
                add_outcome(ccl_pkg::KIND_TX, crc_acc[7:0], 1'b1, verdict);
                close_frame();
                return;
            end

            if (ack)
            begin
                close_frame();
                if (saved_count == 0)
                    verdict = ccl_pkg::ST_NO_PENDING;
                else
                begin
                    void'(pop_saved());
                    verdict = (b == ccl_pkg::ACK_BYTE) ? ccl_pkg::ST_OK : ccl_pkg::ST_BAD_ACK;
                end
                add_outcome(ccl_pkg::KIND_VERDICT, 8'h00, 1'b1, verdict);
                return;
            end

            if (!in_frame)
            begin
                in_frame  = 1'b1;
                frame_dir = 1'b1;
                reply_len = 0;
                if (saved_count == 0)
                begin
                    unseeded = 1'b1;
                    crc_acc  = 16'h0000;
                end
                else
                begin
                    unseeded = 1'b0;
                    crc_acc  = pop_saved();
                end
            end
            crc_acc = crc_fold(crc_acc, b);
            if (reply_len < 3)
                reply_len = reply_len + 1;
            if (!last)
                return;

            if (unseeded)
                verdict = ccl_pkg::ST_NO_PENDING;
            else if (reply_len < 3 || crc_acc != 16'h0000)
                verdict = ccl_pkg::ST_MISMATCH;
            else
                verdict = ccl_pkg::ST_OK;
            close_frame();
            add_outcome(ccl_pkg::KIND_VERDICT, 8'h00, 1'b1, verdict);
        endfunction

        // Compare one accepted output beat with the oldest expectation
        function void check_result(logic kind, logic [7:0] tx, logic last, logic [2:0] code);
            link_result_t want;
            if (outcomes.size() == 0)
            begin
                $error("unexpected result: out_kind %0d tx_byte %02h run_last %0d status %0d",
                       kind, tx, last, code);
                failures++;
                return;
            end
            want = outcomes.pop_front();
            if (kind !== want.kind)
            begin
                $error("out_kind: expected %0d, got %0d", want.kind, kind);
                failures++;
            end
            if (tx !== want.tx)
            begin
                $error("tx_byte: expected %02h, got %02h", want.tx, tx);
                failures++;
            end
            if (last !== want.last)
            begin
                $error("run_last: expected %0d, got %0d", want.last, last);
                failures++;
            end
            if (code !== want.code)
            begin
                $error("status: expected %0d, got %0d", want.code, code);
                failures++;
            end
        endfunction

        function void flag_leftover();
            if (outcomes.size() != 0)
            begin
                $error("%0d expected results never arrived", outcomes.size());
                failures++;
            end
        endfunction

    endclass

endpackage

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int unsigned BEAT_TARGET = 460;

    logic       clk;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_ready;
    logic       direction    = 1'b0;
    logic [7:0] data_byte    = 8'h00;
    logic       frame_last   = 1'b0;
    logic       reply_is_ack = 1'b0;
    logic       out_valid;
    logic       out_ready    = 1'b0;
    logic       out_kind;
    logic [7:0] tx_byte;
    logic       run_last;
    logic [2:0] status;

    crc_link_sb_pkg::crc_link_scoreboard sb;

    // Idle knobs: when set, that side runs back to back with no gaps
    bit          sender_eager   = 1'b0;
    bit          receiver_eager = 1'b0;
    int unsigned beats_sent     = 0;

    chained_crc16_link_checker u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .direction    (direction),
        .data_byte    (data_byte),
        .frame_last   (frame_last),
        .reply_is_ack (reply_is_ack),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_kind     (out_kind),
        .tx_byte      (tx_byte),
        .run_last     (run_last),
        .status       (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case the handshake locks up
    initial
    begin
        #500_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Offer one beat after a random gap, hold it until accepted, then log it.
    // Called at a rising edge; returns at the edge that accepted the beat.
    task automatic send_beat(input logic dir, input logic [7:0] b, input logic last,
                             input logic ack);
        int unsigned gap;
        gap = sender_eager ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        direction    <= dir;
        data_byte    <= b;
        frame_last   <= last;
        reply_is_ack <= ack;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_beat(dir, b, last, ack);
        beats_sent++;
    endtask

    // Command frame of n bytes; the ack flag rides along on send beats and must be ignored
    task automatic send_command(input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            send_beat(1'b0, 8'($urandom_range(0, 255)), i == n - 1, 1'($urandom_range(0, 1)));
    endtask

    // Acknowledge beat; frame_last is don't-care on it
    task automatic send_ack(input logic [7:0] b);
        send_beat(1'b1, b, 1'($urandom_range(0, 1)), 1'b0 | 1'b1);
    endtask

    // Reply payload followed by the CRC that clears the remainder; optionally flip one CRC bit
    task automatic send_reply(input int unsigned payload_len, input logic [15:0] damage);
        logic [15:0] trailer;
        for (int unsigned i = 0; i < payload_len; i++)
            send_beat(1'b1, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
        // The running CRC after the payload is exactly what the far end appends
        trailer = sb.crc_now() ^ damage;
        send_beat(1'b1, trailer[15:8], 1'b0, 1'b0);
        send_beat(1'b1, trailer[7:0], 1'b1, 1'b0);
    endtask

    // Answer one outstanding command: mostly well formed, sometimes broken
    task automatic answer_command();
        int unsigned pick;
        int unsigned n;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            send_reply($urandom_range(1, 4), 16'h0000);
        else if (pick < 70)
            send_ack(ccl_pkg::ACK_BYTE);
        else if (pick < 77)
            send_ack(8'($urandom_range(0, 254)));
        else if (pick < 85)
            send_reply($urandom_range(1, 4), 16'(1 << $urandom_range(0, 15)));
        else if (pick < 92)
        begin
            // too short to carry a CRC
            n = $urandom_range(1, 2);
            for (int unsigned i = 0; i < n; i++)
                send_beat(1'b1, 8'($urandom_range(0, 255)), i == n - 1, 1'b0);
        end
        else
        begin
            // leave the reply open; whatever comes next abandons or extends it
            n = $urandom_range(1, 3);
            repeat (n) send_beat(1'b1, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
        end
    endtask

    task automatic send_noise(input int unsigned n);
        repeat (n)
            send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // Overfill the pending store, then drain it with acks
    task automatic flood_queue();
        repeat (ccl_pkg::QUEUE_DEPTH_DEF + 2)
            send_beat(1'b0, 8'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1)));
        while (sb.pending_depth() != 0)
            send_ack(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                 : ccl_pkg::ACK_BYTE);
    endtask

    task automatic run_directed();
        // Ack with nothing pending: no pop
        send_beat(1'b1, ccl_pkg::ACK_BYTE, 1'b1, 1'b1);
        // Reply with nothing pending folds from zero
        send_beat(1'b1, 8'h00, 1'b0, 1'b0);
        send_beat(1'b1, 8'hAB, 1'b1, 1'b0);
        // Two-byte command at the data extremes, then a matching reply
        send_beat(1'b0, 8'h00, 1'b0, 1'b0);
        send_beat(1'b0, 8'hFF, 1'b1, 1'b0);
        send_reply(1, 16'h0000);
        // Ack flag on a send beat is ignored; a bad ack still pops
        send_beat(1'b0, 8'h55, 1'b1, 1'b1);
        send_beat(1'b1, 8'h00, 1'b1, 1'b1);
        // Short reply
        send_beat(1'b0, 8'h12, 1'b1, 1'b0);
        send_beat(1'b1, 8'h80, 1'b0, 1'b0);
        send_beat(1'b1, 8'h7F, 1'b1, 1'b0);
        // Ack lands mid-reply with frame_last low: the reply is dropped, its seed stays popped
        send_beat(1'b0, 8'h34, 1'b1, 1'b0);
        send_beat(1'b1, 8'hC3, 1'b0, 1'b0);
        send_beat(1'b1, 8'hFF, 1'b0, 1'b1);
        // Direction flips mid-frame both ways
        send_beat(1'b0, 8'hA5, 1'b0, 1'b1);
        send_beat(1'b1, 8'h01, 1'b1, 1'b0);
        send_beat(1'b0, 8'h5A, 1'b0, 1'b0);
        send_beat(1'b1, 8'h3C, 1'b0, 1'b0);
        send_beat(1'b0, 8'h7E, 1'b1, 1'b0);
        // Reply with a CRC that does not fit
        send_beat(1'b1, 8'h11, 1'b0, 1'b0);
        send_beat(1'b1, 8'h22, 1'b0, 1'b0);
        send_beat(1'b1, 8'h33, 1'b1, 1'b0);
    endtask

    // Receiver: random back-pressure, plus one long hold-off to back the block up
    initial
    begin : drain_results
        int unsigned stall;
        int unsigned results_seen;
        bit          held_off;
        results_seen = 0;
        held_off     = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = receiver_eager ? 0 : $urandom_range(0, 15);
            if (!held_off && results_seen >= 150)
            begin
                stall    = 400;
                held_off = 1'b1;
            end
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            sb.check_result(out_kind, tx_byte, run_last, status);
            results_seen++;
        end
    end

    initial
    begin : stimulus
        int unsigned pick;
        int unsigned k;
        int unsigned settle;
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        flood_queue();

        // Mostly command/reply exchanges, some pipelined several deep
        while (beats_sent < BEAT_TARGET)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                sender_eager   = ($urandom_range(0, 2) == 0);
                receiver_eager = ($urandom_range(0, 2) == 0);
            end
            pick = $urandom_range(0, 199);
            if (pick < 170)
            begin
                k = (pick < 110) ? 1 : $urandom_range(2, 4);
                repeat (k) send_command($urandom_range(1, 5));
                repeat (k) answer_command();
            end
            else if (pick < 188)
                send_noise($urandom_range(1, 6));
            else if (pick < 199)
            begin
                // drop stale entries left behind by noise
                while (sb.pending_depth() != 0)
                    send_ack(ccl_pkg::ACK_BYTE);
            end
            else
                flood_queue();
        end
        in_valid <= 1'b0;

        // Wait for the tail, bounded, then let the pipeline settle before the final check
        settle = 0;
        while (sb.waiting() != 0 && settle < 20000)
        begin
            @(posedge clk);
            settle++;
        end
        repeat (8) @(posedge clk);
        sb.flag_leftover();

        if (sb.failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ccl_pkg.sv
rtl/ccl_front.sv
rtl/ccl_fifo.sv
rtl/ccl_back.sv
rtl/chained_crc16_link_checker.sv
test/crc_link_sb_pkg.sv
test/tb_top.sv
